// File: rtl/u8d_pkg.sv
// shared types, constants and helpers for the lenient utf-8 decoder
package u8d_pkg;

  localparam int BYTE_W     = 8;
  localparam int CP_W       = 21;
  localparam int PEND_W     = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] LEAD2_MIN    = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
  localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h3F;
  localparam logic [BYTE_W-1:0] TERMINATOR   = 8'h00;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [PEND_W-1:0] pend_t;

  typedef struct packed {
    cp_t  code_point;
    logic last_of_run;
  } result_t;

  // results produced by one byte, first goes out first
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } dec_out_t;

  // continuation bytes expected after a lead byte
  function automatic pend_t lead_extra(input byte_t b);
    pend_t extra;
    if (b >= LEAD4_MIN) begin
      extra = 2'd3;
    end else if (b >= LEAD3_MIN) begin
      extra = 2'd2;
    end else begin
      extra = 2'd1;
    end
    return extra;
  endfunction

endpackage

// File: rtl/u8d_core.sv
// decode step: sequence state registers and the per-byte result logic
module u8d_core
  import u8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  byte_t    data_byte,
  output dec_out_t dec_out
);

  cp_t   acc;
  cp_t   acc_next;
  pend_t pend;
  pend_t pend_next;

  logic  is_cont;
  logic  is_lead;
  pend_t extra;
  byte_t lead_bits;
  cp_t   acc_shift;
  cp_t   byte_cp;

  always_comb begin
    is_cont   = (data_byte & CONT_MASK) == CONT_TAG;
    is_lead   = data_byte >= LEAD2_MIN;
    extra     = lead_extra(data_byte);
    lead_bits = data_byte & (PAYLOAD_MASK >> extra);
    acc_shift = {acc[CP_W-7:0], data_byte[5:0]};
    byte_cp   = {{(CP_W-BYTE_W){1'b0}}, data_byte};
  end

  always_comb begin
    acc_next = acc;
    pend_next = pend;
    dec_out.count = 2'd0;
    dec_out.first = '{code_point: acc, last_of_run: 1'b1};
    dec_out.second = '{code_point: byte_cp, last_of_run: 1'b1};
    priority if (data_byte == TERMINATOR) begin
      // flush a partial value, drop the terminator itself
      if (pend != '0) begin
        dec_out.count = 2'd1;
      end
      acc_next = '0;
      pend_next = '0;
    end else if (pend != '0 && is_cont) begin
      pend_next = pend - 2'd1;
      if (pend == 2'd1) begin
        dec_out.count = 2'd1;
        dec_out.first.code_point = acc_shift;
        acc_next = '0;
      end else begin
        acc_next = acc_shift;
      end
    end else begin
      // not a continuation: a cut-short partial value goes first
      if (is_lead) begin
        dec_out.count = (pend != '0) ? 2'd1 : 2'd0;
        acc_next = {{(CP_W-BYTE_W){1'b0}}, lead_bits};
        pend_next = extra;
      end else begin
        acc_next = '0;
        pend_next = '0;
        if (pend != '0) begin
          dec_out.count = 2'd2;
          dec_out.first.last_of_run = 1'b0;
        end else begin
          dec_out.count = 2'd1;
          dec_out.first = '{code_point: byte_cp, last_of_run: 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pend <= '0;
    end else if (fire) begin
      acc <= acc_next;
      pend <= pend_next;
    end
  end

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    fire && data_byte == TERMINATOR |=> pend == '0 && acc == '0)
    else $error("terminator left a sequence open");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    dec_out.count == 2'd2 |-> !dec_out.first.last_of_run && dec_out.second.last_of_run)
    else $error("two results with wrong last flags");

  a_no_third: assert property (@(posedge clk) disable iff (rst)
    dec_out.count != 2'd3)
    else $error("more than two results from one byte");

endmodule

// File: rtl/u8d_fifo.sv
// result queue: takes up to two results a cycle, hands out one unless stalled
module u8d_fifo
  import u8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  dec_out_t dec_out,
  output logic     room,
  output result_t  head,
  output logic     out_valid,
  input  logic     out_stall
);

  result_t         mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [1:0]       push_n;
  logic             pop;

  assign push_n    = push ? dec_out.count : 2'd0;
  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = mem[rd_ptr];
  // room for a full pair, judged on registered count only
  assign room      = count <= CNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= dec_out.first;
    end
    if (push_n == 2'd2) begin
      mem[PTR_W'(wr_ptr + 1'b1)] <= dec_out.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> count <= CNT_W'(FIFO_DEPTH - 2))
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule

// File: rtl/utf8_lenient_decoder.sv
// top level of the lenient utf-8 decoder: input register, decode step, result queue
//
// channel   dir  handshake           payload
// in        in   in_valid/in_stall   data_byte[7:0]
// out       out  out_valid/out_stall code_point[20:0], last_of_run
//
// one byte transfer is taken per cycle while in_stall is low; a byte waits in the
// input register until the queue has room, then is decoded into the result queue
// a byte gives zero, one or two results; the output side moves one result per cycle
// unless out_stall is high, so cut-short runs are limited by the output port
// in_stall rises only when the registered queue fill leaves no room for a pair
// of results, so there is no combinational path from out_stall to in_stall
// rst clears the sequence state, the input register's full flag and the queue
module utf8_lenient_decoder
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic        last_of_run
);

  // input register
  logic     in_full;
  byte_t    byte_r;
  logic     room;
  logic     fire;
  dec_out_t dec_out;
  result_t  head;

  // decode the held byte when the queue can take both results
  assign fire     = in_full && room;
  assign in_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  // payload register, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= data_byte;
    end
  end

  u8d_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (byte_r),
    .dec_out   (dec_out)
  );

  u8d_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .dec_out   (dec_out),
    .room      (room),
    .head      (head),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  assign code_point  = head.code_point;
  assign last_of_run = head.last_of_run;

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_full && !fire)
    else $error("stall raised with nothing waiting");

endmodule

// File: tb/utf8_lenient_decoder_test.sv
// self-checking testbench for the lenient utf-8 decoder: directed table, random text, stalls
module utf8_lenient_decoder_test;
  import u8d_pkg::*;

  localparam int RANDOM_TEXT_BYTES = 1200;
  localparam int HOLD_AFTER_BYTES  = 400;    // receiver hold-off starts past this point
  localparam int HOLD_CYCLES       = 200;
  localparam int DRAIN_CYCLES      = 24;     // extra wait for stray results after the expected ones drain
  localparam int CYCLE_LIMIT       = 300000;
  localparam int DIRECTED_ROWS     = 25;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  byte_t data_byte = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  cp_t   code_point;
  logic  last_of_run;

  utf8_lenient_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // synchronous reset, released on a falling edge
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // decoder state mirror and expected code points
  // ---------------------------------------------------------------------------
  cp_t     seq_value;       // bits gathered so far for the open sequence
  pend_t   seq_remaining;   // continuation bytes still owed, 0 when idle
  result_t pending_code_points[$];

  int error_count;
  int bytes_offered;
  int text_bytes;
  int codes_checked;
  int partials_seen;
  int input_held_cycles;
  int cycle_count;
  bit sender_quiet;
  bit hold_done;

  // one byte through the decoder; returns how many code points it gives
  function automatic int decode_byte(input byte_t b, output result_t first,
                                     output result_t second);
    int      n;
    bit      cut;
    result_t partial;
    n       = 0;
    cut     = 1'b0;
    first   = '0;
    second  = '0;
    partial = '0;
    // terminator flushes an open sequence and always leaves the decoder idle
    if (b == TERMINATOR) begin
      if (seq_remaining != '0) begin
        first = '{code_point: seq_value, last_of_run: 1'b1};
        n = 1;
      end
      seq_value     = '0;
      seq_remaining = '0;
      return n;
    end
    if (seq_remaining != '0) begin
      if ((b & CONT_MASK) == CONT_TAG) begin
        seq_value     = {seq_value[CP_W-7:0], b[5:0]};
        seq_remaining = seq_remaining - 1'b1;
        if (seq_remaining == '0) begin
          first = '{code_point: seq_value, last_of_run: 1'b1};
          seq_value = '0;
          n = 1;
        end
        return n;
      end
      // sequence cut short: the partial value goes out ahead of the new byte
      cut           = 1'b1;
      partial       = '{code_point: seq_value, last_of_run: 1'b0};
      seq_value     = '0;
      seq_remaining = '0;
    end
    if (b >= LEAD2_MIN) begin
      // a lead opens a sequence and emits nothing of its own
      seq_remaining = (b >= LEAD4_MIN) ? 2'd3 : (b >= LEAD3_MIN) ? 2'd2 : 2'd1;
      seq_value     = cp_t'(b & (PAYLOAD_MASK >> seq_remaining));
      if (cut) begin
        first = '{code_point: partial.code_point, last_of_run: 1'b1};
        n = 1;
      end
    end else begin
      // ascii and stray continuation bytes pass through unchanged
      if (cut) begin
        first  = partial;
        second = '{code_point: cp_t'(b), last_of_run: 1'b1};
        n = 2;
      end else begin
        first = '{code_point: cp_t'(b), last_of_run: 1'b1};
        n = 1;
      end
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // append one expected result behind those already waiting
  task automatic queue_result(input result_t r);
    pending_code_points = {pending_code_points, r};
  endtask

  // ---------------------------------------------------------------------------
  // input side: idle gaps drawn per byte, with quiet stretches of back-to-back transfers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input byte_t b);
    int gap;
    if (bytes_offered % 64 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
    gap = sender_quiet ? 0 : $urandom_range(0, 9);
    bytes_offered++;
    if (b != TERMINATOR) text_bytes++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    // transfer happens at the first rising edge with stall low
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text_byte(input byte_t b);
    result_t first;
    result_t second;
    int      n;
    send_byte(b);
    n = decode_byte(b, first, second);
    if (n > 0) queue_result(first);
    if (n > 1) queue_result(second);
  endtask

  // mostly well-formed characters with random payload; the rest terminators,
  // truncated sequences and raw noise
  task automatic send_random_chunk();
    int    kind;
    int    extra;
    int    conts;
    byte_t lead;
    kind  = $urandom_range(0, 99);
    extra = $urandom_range(1, 3);
    case (extra)
      1:       lead = byte_t'($urandom_range(8'hC0, 8'hDF));
      2:       lead = byte_t'($urandom_range(8'hE0, 8'hEF));
      default: lead = byte_t'($urandom_range(8'hF0, 8'hFF));
    endcase
    if (kind < 15) begin
      send_text_byte(byte_t'($urandom_range(1, 127)));
    end else if (kind < 65) begin
      send_text_byte(lead);
      repeat (extra) send_text_byte(CONT_TAG | byte_t'($urandom_range(0, 63)));
    end else if (kind < 75) begin
      send_text_byte(TERMINATOR);
    end else if (kind < 88) begin
      // truncated: whatever follows cuts it short
      conts = $urandom_range(0, extra - 1);
      send_text_byte(lead);
      repeat (conts) send_text_byte(CONT_TAG | byte_t'($urandom_range(0, 63)));
    end else begin
      send_text_byte(byte_t'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table: extremes, every byte class, cut-short and terminator cases;
  // rows with typed = 0 take their expectation from decode_byte
  // ---------------------------------------------------------------------------
  typedef struct {
    byte_t   b;
    bit      typed;
    int      count;
    result_t first;
    result_t second;
  } directed_row_t;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{TERMINATOR, 1, 0, '0, '0},                          // terminator while idle
    '{8'h41, 1, 1, '{21'h000041, 1'b1}, '0},
    '{8'h7F, 1, 1, '{21'h00007F, 1'b1}, '0},
    '{8'h01, 1, 1, '{21'h000001, 1'b1}, '0},
    '{8'h80, 1, 1, '{21'h000080, 1'b1}, '0},              // stray continuation
    '{8'hBF, 1, 1, '{21'h0000BF, 1'b1}, '0},
    '{8'hC2, 0, 0, '0, '0},
    '{8'hA9, 1, 1, '{21'h0000A9, 1'b1}, '0},
    '{8'hE2, 0, 0, '0, '0},
    '{8'h82, 0, 0, '0, '0},
    '{8'hAC, 1, 1, '{21'h0020AC, 1'b1}, '0},
    '{8'hF0, 0, 0, '0, '0},
    '{8'h9F, 0, 0, '0, '0},
    '{8'h98, 0, 0, '0, '0},
    '{8'h80, 1, 1, '{21'h01F600, 1'b1}, '0},
    '{8'hFF, 0, 0, '0, '0},                               // 0xf8..0xff act as 4-byte leads
    '{8'hBF, 0, 0, '0, '0},
    '{8'hBF, 0, 0, '0, '0},
    '{8'hBF, 1, 1, '{21'h1FFFFF, 1'b1}, '0},              // largest code point
    '{8'hC3, 0, 0, '0, '0},
    '{8'h42, 1, 2, '{21'h000003, 1'b0}, '{21'h000042, 1'b1}}, // cut by ascii
    '{8'hE0, 0, 0, '0, '0},
    '{8'hF8, 1, 1, '{21'h000000, 1'b1}, '0},              // lead after cut
    '{8'h80, 0, 0, '0, '0},
    '{TERMINATOR, 1, 1, '{21'h000000, 1'b1}, '0}          // terminator flushes partial
  };

  initial begin : stimulus
    result_t first;
    result_t second;
    int      n;
    seq_value     = '0;
    seq_remaining = '0;
    wait (!rst);
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].b);
      n = decode_byte(directed_rows[i].b, first, second);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].count > 0) queue_result(directed_rows[i].first);
        if (directed_rows[i].count > 1) queue_result(directed_rows[i].second);
      end else begin
        if (n > 0) queue_result(first);
        if (n > 1) queue_result(second);
      end
    end
    text_bytes = 0;
    while (text_bytes < RANDOM_TEXT_BYTES) send_random_chunk();
    @(negedge clk);
    in_valid <= 1'b0;
    // drain, then give the block time to show any stray result
    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes over %0d cycles, %0d code points checked, %0d cut-short partials",
             bytes_offered, cycle_count, codes_checked, partials_seen);
    $display("input held off by the block for %0d cycles while a byte was offered",
             input_held_cycles);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // output side: random stall per result, one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    int      stall_n;
    int      taken;
    bit      quiet;
    result_t want;
    wait (!rst);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      stall_n = quiet ? 0 : $urandom_range(0, 9);
      if (!hold_done && bytes_offered >= HOLD_AFTER_BYTES) begin
        // long hold while the sender keeps offering, so the queue fills
        hold_done = 1'b1;
        stall_n   = HOLD_CYCLES;
      end
      repeat (stall_n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (pending_code_points.size() == 0) begin
        report_mismatch($sformatf("code point %h last %b with none expected",
                                  code_point, last_of_run));
      end else begin
        want = pending_code_points.pop_front();
        codes_checked++;
        if (!want.last_of_run) partials_seen++;
        if (code_point !== want.code_point)
          report_mismatch($sformatf("code_point %h, expected %h", code_point, want.code_point));
        if (last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, expected %b (code point %h)",
                                    last_of_run, want.last_of_run, want.code_point));
      end
    end
  end

  // cycle count, back-pressure seen on the input, and the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && in_valid && in_stall) input_held_cycles <= input_held_cycles + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

endmodule

// File: files.f
rtl/u8d_pkg.sv
rtl/u8d_core.sv
rtl/u8d_fifo.sv
rtl/utf8_lenient_decoder.sv
tb/utf8_lenient_decoder_test.sv
